/* hdl/first_fit_aligned_allocator_defines.svh */
// Assertion macros for the allocator.
`ifndef FIRST_FIT_ALIGNED_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_ALIGNED_ALLOCATOR_DEFINES_SVH

// Checks a property on every clock edge outside reset.
`define FFAA_CHECK(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("allocator check failed");

// Checks that a condition in one cycle leads to another in the next cycle.
`define FFAA_NEXT(label, cond, next) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (next)) \
        else $error("allocator sequencing check failed");

`endif

/* hdl/ffaa_pkg.sv */
`default_nettype none
package ffaa_pkg;
    localparam int MAX_SEGMENTS = 16;
    // ALIGN_BYTES must be a power of two.
    localparam int ALIGN_BYTES = 64;
    localparam int IDX_W = $clog2(MAX_SEGMENTS);
    localparam int CNT_W = IDX_W + 1;
    localparam logic [31:0] ALIGN_MASK = 32'(ALIGN_BYTES - 1);
    localparam logic [31:0] REQ_LIMIT = 32'hFFFF_FFFF - ALIGN_MASK;

    localparam logic [2:0] ST_GRANTED    = 3'd0;
    localparam logic [2:0] ST_ALLOC_FAIL = 3'd1;
    localparam logic [2:0] ST_RELEASED   = 3'd2;
    localparam logic [2:0] ST_IGNORED    = 3'd3;
    localparam logic [2:0] ST_LOST       = 3'd4;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_WRITE,
        OP_INSERT,
        OP_REMOVE,
        OP_MERGE
    } t_op;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_ALLOC  = 6'b000010,
        S_REL    = 6'b000100,
        S_BRIDGE = 6'b001000,
        S_INSERT = 6'b010000,
        S_OUT    = 6'b100000
    } t_state;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction
endpackage
`default_nettype wire

/* hdl/first_fit_aligned_allocator.sv */
// First-fit allocator over an address-ordered table of up to 16 free segments, granting
// blocks aligned to 64 bytes. One command is taken at a time: o_ready is high only while the
// block is idle with no result pending. A command walks the table one entry per cycle,
// using the single compare-and-update unit that visits the table entries in turn.
// Table inserts and removals shift the entries from the affected position onward in parallel.
`default_nettype none
`include "first_fit_aligned_allocator_defines.svh"
module first_fit_aligned_allocator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_command,
    input  wire logic [31:0] i_region_address,
    input  wire logic [31:0] i_region_length,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_status,
    output logic [31:0]      o_granted_address,
    output logic [31:0]      o_granted_length
);
    localparam int N = ffaa_pkg::MAX_SEGMENTS;
    localparam int IW = ffaa_pkg::IDX_W;
    localparam int CW = ffaa_pkg::CNT_W;

    logic [31:0] r_base [N];
    logic [31:0] r_len [N];
    logic [CW-1:0] r_count, n_count;
    ffaa_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_pos, n_pos;
    logic [31:0] r_addr, n_addr;
    logic [31:0] r_rlen, n_rlen;
    logic [31:0] r_size, n_size;
    logic [31:0] r_acc_base, n_acc_base;
    logic [31:0] r_acc_len, n_acc_len;
    logic [2:0] r_status, n_status;
    logic [31:0] r_gaddr, n_gaddr;
    logic [31:0] r_glen, n_glen;

    ffaa_pkg::t_op op;
    logic [CW-1:0] op_pos;
    logic [31:0] op_base, op_len;

    logic [31:0] cur_base, cur_len;
    logic [31:0] pad;
    logic [31:0] avail;
    logic [31:0] rest;
    logic [31:0] aligned;
    logic [31:0] merged;
    logic [32:0] rel_end;
    logic [32:0] cur_end;
    logic [32:0] acc_end;
    logic at_end;
    logic full;

    assign o_ready = (r_state == ffaa_pkg::S_IDLE);
    assign o_valid = (r_state == ffaa_pkg::S_OUT);
    assign o_status = r_status;
    assign o_granted_address = r_gaddr;
    assign o_granted_length = r_glen;

    assign cur_base = r_base[r_pos[IW-1:0]];
    assign cur_len = r_len[r_pos[IW-1:0]];
    assign pad = (32'd0 - cur_base) & ffaa_pkg::ALIGN_MASK;
    assign avail = cur_len - pad;
    assign rest = avail - r_size;
    assign aligned = cur_base + pad;
    assign merged = ffaa_pkg::sat_add(cur_len, r_rlen);
    assign rel_end = {1'b0, r_addr} + {1'b0, r_rlen};
    assign cur_end = {1'b0, cur_base} + {1'b0, cur_len};
    assign acc_end = {1'b0, r_acc_base} + {1'b0, r_acc_len};
    assign at_end = (r_pos == r_count);
    assign full = (r_count == CW'(N));

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_pos = r_pos;
        n_addr = r_addr;
        n_rlen = r_rlen;
        n_size = r_size;
        n_acc_base = r_acc_base;
        n_acc_len = r_acc_len;
        n_status = r_status;
        n_gaddr = r_gaddr;
        n_glen = r_glen;
        op = ffaa_pkg::OP_NONE;
        op_pos = r_pos;
        op_base = r_addr;
        op_len = r_rlen;
        unique case (r_state)
            ffaa_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_addr = i_region_address;
                    n_rlen = i_region_length;
                    n_size = (i_region_length + ffaa_pkg::ALIGN_MASK)
                        & ~ffaa_pkg::ALIGN_MASK;
                    n_pos = '0;
                    n_gaddr = '0;
                    n_glen = '0;
                    if (!i_command) begin
                        if (i_region_length == 32'd0
                                || i_region_length > ffaa_pkg::REQ_LIMIT) begin
                            n_status = ffaa_pkg::ST_ALLOC_FAIL;
                            n_state = ffaa_pkg::S_OUT;
                        end else begin
                            n_state = ffaa_pkg::S_ALLOC;
                        end
                    end else begin
                        if (i_region_address == 32'd0 || i_region_length == 32'd0) begin
                            n_status = ffaa_pkg::ST_IGNORED;
                            n_state = ffaa_pkg::S_OUT;
                        end else begin
                            n_status = ffaa_pkg::ST_RELEASED;
                            n_state = ffaa_pkg::S_REL;
                        end
                    end
                end
            end
            ffaa_pkg::S_ALLOC: begin
                if (at_end) begin
                    n_status = ffaa_pkg::ST_ALLOC_FAIL;
                    n_state = ffaa_pkg::S_OUT;
                end else if (pad <= cur_len && avail >= r_size) begin
                    n_status = ffaa_pkg::ST_GRANTED;
                    n_gaddr = aligned;
                    n_glen = r_size;
                    n_state = ffaa_pkg::S_OUT;
                    if (pad == 32'd0) begin
                        if (cur_len == r_size) begin
                            op = ffaa_pkg::OP_REMOVE;
                            n_count = r_count - CW'(1);
                        end else begin
                            op = ffaa_pkg::OP_WRITE;
                            op_base = cur_base + r_size;
                            op_len = cur_len - r_size;
                        end
                    end else begin
                        op = ffaa_pkg::OP_WRITE;
                        op_base = cur_base;
                        op_len = pad;
                        if (rest != 32'd0) begin
                            if (full) begin
                                n_glen = r_size + rest;
                            end else begin
                                n_addr = aligned + r_size;
                                n_rlen = rest;
                                n_pos = r_pos + CW'(1);
                                n_state = ffaa_pkg::S_INSERT;
                            end
                        end
                    end
                end else begin
                    n_pos = r_pos + CW'(1);
                end
            end
            ffaa_pkg::S_REL: begin
                if (at_end) begin
                    if (full) begin
                        n_status = ffaa_pkg::ST_LOST;
                        n_state = ffaa_pkg::S_OUT;
                    end else begin
                        n_state = ffaa_pkg::S_INSERT;
                    end
                end else if (rel_end == {1'b0, cur_base}) begin
                    op = ffaa_pkg::OP_WRITE;
                    op_base = r_addr;
                    op_len = merged;
                    n_status = ffaa_pkg::ST_RELEASED;
                    n_state = ffaa_pkg::S_OUT;
                end else if (cur_end == {1'b0, r_addr}) begin
                    op = ffaa_pkg::OP_WRITE;
                    op_base = cur_base;
                    op_len = merged;
                    n_status = ffaa_pkg::ST_RELEASED;
                    n_acc_base = cur_base;
                    n_acc_len = merged;
                    if (r_pos + CW'(1) < r_count) begin
                        n_pos = r_pos + CW'(1);
                        n_state = ffaa_pkg::S_BRIDGE;
                    end else begin
                        n_state = ffaa_pkg::S_OUT;
                    end
                end else if (r_addr < cur_base) begin
                    if (full) begin
                        n_status = ffaa_pkg::ST_LOST;
                        n_state = ffaa_pkg::S_OUT;
                    end else begin
                        n_state = ffaa_pkg::S_INSERT;
                    end
                end else begin
                    n_pos = r_pos + CW'(1);
                end
            end
            ffaa_pkg::S_BRIDGE: begin
                n_state = ffaa_pkg::S_OUT;
                if (acc_end == {1'b0, cur_base}) begin
                    op = ffaa_pkg::OP_MERGE;
                    op_len = ffaa_pkg::sat_add(r_acc_len, cur_len);
                    n_count = r_count - CW'(1);
                end
            end
            ffaa_pkg::S_INSERT: begin
                op = ffaa_pkg::OP_INSERT;
                n_count = r_count + CW'(1);
                n_state = ffaa_pkg::S_OUT;
            end
            ffaa_pkg::S_OUT: begin
                if (i_ready) begin
                    n_state = ffaa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ffaa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffaa_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_addr <= n_addr;
        r_rlen <= n_rlen;
        r_size <= n_size;
        r_acc_base <= n_acc_base;
        r_acc_len <= n_acc_len;
        r_status <= n_status;
        r_gaddr <= n_gaddr;
        r_glen <= n_glen;
    end

    for (genvar g = 0; g < N; g++) begin : g_entry
        localparam logic [CW-1:0] K = CW'(g);
        localparam int PREV = (g > 0) ? g - 1 : 0;
        localparam int NEXT = (g < N - 1) ? g + 1 : N - 1;
        always_ff @(posedge i_clk) begin
            unique case (op)
                ffaa_pkg::OP_WRITE: begin
                    if (K == op_pos) begin
                        r_base[g] <= op_base;
                        r_len[g] <= op_len;
                    end
                end
                ffaa_pkg::OP_INSERT: begin
                    if (K == op_pos) begin
                        r_base[g] <= op_base;
                        r_len[g] <= op_len;
                    end else if (K > op_pos) begin
                        r_base[g] <= r_base[PREV];
                        r_len[g] <= r_len[PREV];
                    end
                end
                ffaa_pkg::OP_REMOVE: begin
                    if (K >= op_pos && g < N - 1) begin
                        r_base[g] <= r_base[NEXT];
                        r_len[g] <= r_len[NEXT];
                    end
                end
                ffaa_pkg::OP_MERGE: begin
                    if (K + CW'(1) == op_pos) begin
                        r_len[g] <= op_len;
                    end else if (K >= op_pos && g < N - 1) begin
                        r_base[g] <= r_base[NEXT];
                        r_len[g] <= r_len[NEXT];
                    end
                end
                ffaa_pkg::OP_NONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    `FFAA_CHECK(a_count_bound, r_count <= CW'(N))
    `FFAA_CHECK(a_zero_unless_granted,
        (o_valid && o_status != ffaa_pkg::ST_GRANTED)
            |-> (o_granted_address == 32'd0 && o_granted_length == 32'd0))
    `FFAA_CHECK(a_grant_nonzero,
        (o_valid && o_status == ffaa_pkg::ST_GRANTED) |-> o_granted_length != 32'd0)
    `FFAA_NEXT(a_insert_grows, r_state == ffaa_pkg::S_INSERT, r_count == $past(r_count) + CW'(1))
endmodule
`default_nettype wire

/* dv/tb_first_fit_aligned_allocator.sv */
`default_nettype none
module tb_first_fit_aligned_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    class alloc_scoreboard;
        logic [31:0] seg_base[ffaa_pkg::MAX_SEGMENTS];
        logic [31:0] seg_len[ffaa_pkg::MAX_SEGMENTS];
        int unsigned seg_count;
        logic [2:0]  exp_status[$];
        logic [31:0] exp_addr[$];
        logic [31:0] exp_len[$];
        int unsigned mismatches;

        function new();
            seg_count = 0;
            mismatches = 0;
        endfunction

        function void remove_at(int unsigned pos);
            for (int unsigned i = pos; i + 1 < seg_count; i++) begin
                seg_base[i] = seg_base[i + 1];
                seg_len[i] = seg_len[i + 1];
            end
            seg_count--;
        endfunction

        function void insert_at(int unsigned pos, logic [31:0] b, logic [31:0] l);
            for (int unsigned i = seg_count; i > pos; i--) begin
                seg_base[i] = seg_base[i - 1];
                seg_len[i] = seg_len[i - 1];
            end
            seg_base[pos] = b;
            seg_len[pos] = l;
            seg_count++;
        endfunction

        function logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
            logic [32:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[32] ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        function logic [2:0] allocate(logic [31:0] req, output logic [31:0] ga,
                                      output logic [31:0] gl);
            logic [63:0] al, sz, b, l, pad, avail, rest;
            al = ffaa_pkg::ALIGN_BYTES;
            ga = 0;
            gl = 0;
            if (req == 0 || {32'd0, req} > 64'hFFFF_FFFF - (al - 1))
                return ffaa_pkg::ST_ALLOC_FAIL;
            sz = (({32'd0, req} + al - 1) / al) * al;
            for (int unsigned i = 0; i < seg_count; i++) begin
                b = seg_base[i];
                l = seg_len[i];
                pad = (al - (b % al)) % al;
                if (pad > l) continue;
                avail = l - pad;
                if (avail < sz) continue;
                ga = 32'(b + pad);
                gl = 32'(sz);
                if (pad == 0) begin
                    seg_base[i] = 32'(b + sz);
                    seg_len[i] = 32'(l - sz);
                    if (seg_len[i] == 0) remove_at(i);
                end else begin
                    seg_len[i] = 32'(pad);
                    rest = avail - sz;
                    if (rest != 0) begin
                        if (seg_count < ffaa_pkg::MAX_SEGMENTS)
                            insert_at(i + 1, 32'(b + pad + sz), 32'(rest));
                        else gl = 32'(sz + rest);
                    end
                end
                return ffaa_pkg::ST_GRANTED;
            end
            return ffaa_pkg::ST_ALLOC_FAIL;
        endfunction

        function logic [2:0] release_region(logic [31:0] a, logic [31:0] l);
            logic [32:0] e;
            if (a == 0 || l == 0) return ffaa_pkg::ST_IGNORED;
            e = {1'b0, a} + {1'b0, l};
            for (int unsigned i = 0; i < seg_count; i++) begin
                if (e == {1'b0, seg_base[i]}) begin
                    seg_base[i] = a;
                    seg_len[i] = add_sat(seg_len[i], l);
                    return ffaa_pkg::ST_RELEASED;
                end
                if ({1'b0, seg_base[i]} + {1'b0, seg_len[i]} == {1'b0, a}) begin
                    seg_len[i] = add_sat(seg_len[i], l);
                    if (i + 1 < seg_count && {1'b0, seg_base[i]} + {1'b0, seg_len[i]}
                            == {1'b0, seg_base[i + 1]}) begin
                        seg_len[i] = add_sat(seg_len[i], seg_len[i + 1]);
                        remove_at(i + 1);
                    end
                    return ffaa_pkg::ST_RELEASED;
                end
                if (a < seg_base[i]) begin
                    if (seg_count >= ffaa_pkg::MAX_SEGMENTS) return ffaa_pkg::ST_LOST;
                    insert_at(i, a, l);
                    return ffaa_pkg::ST_RELEASED;
                end
            end
            if (seg_count >= ffaa_pkg::MAX_SEGMENTS) return ffaa_pkg::ST_LOST;
            insert_at(seg_count, a, l);
            return ffaa_pkg::ST_RELEASED;
        endfunction

        function void note_command(logic cmd, logic [31:0] a, logic [31:0] l);
            logic [2:0] st;
            logic [31:0] ga, gl;
            ga = 0;
            gl = 0;
            if (cmd == 1'b0) st = allocate(l, ga, gl);
            else st = release_region(a, l);
            exp_status.push_back(st);
            exp_addr.push_back(ga);
            exp_len.push_back(gl);
        endfunction

        function void check_result(logic [2:0] st, logic [31:0] ga, logic [31:0] gl);
            logic [2:0] es;
            logic [31:0] ea, el;
            if (exp_status.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat: status %0d", st);
                return;
            end
            es = exp_status.pop_front();
            ea = exp_addr.pop_front();
            el = exp_len.pop_front();
            if (st !== es || ga !== ea || gl !== el) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %0d %h %h, got %0d %h %h",
                             es, ea, el, st, ga, gl);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_command = 1'b0;
    logic [31:0] i_region_address = '0;
    logic [31:0] i_region_length = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_status;
    logic [31:0] o_granted_address;
    logic [31:0] o_granted_length;

    alloc_scoreboard sb = new();
    bit hold_off = 1'b0;
    logic [31:0] live_base[$];
    logic [31:0] live_len[$];

    first_fit_aligned_allocator u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge i_clk) begin
        if (i_valid && o_ready) sb.note_command(i_command, i_region_address, i_region_length);
        if (o_valid && i_ready) begin
            sb.check_result(o_status, o_granted_address, o_granted_length);
            if (o_status == ffaa_pkg::ST_GRANTED) begin
                live_base.push_back(o_granted_address);
                live_len.push_back(o_granted_length);
            end
        end
    end

    initial begin
        int unsigned g;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off) begin
                i_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            g = gap_len();
            if (g > 0) begin
                i_ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    task automatic send(logic cmd, logic [31:0] a, logic [31:0] l);
        int unsigned g;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_region_address <= a;
        i_region_length <= l;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.exp_status.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_len();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return $urandom_range(1, 3) * ffaa_pkg::ALIGN_BYTES;
            default: return $urandom_range(1, 4000);
        endcase
    endfunction

    initial begin
        int unsigned k;
        logic [31:0] a;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send(1'b0, 0, 64);
        send(1'b1, 0, 100);
        send(1'b1, 32'h1000, 0);
        send(1'b1, 32'h1000, 32'h4000);
        send(1'b0, 0, 0);
        send(1'b0, 0, 32'hFFFF_FFFF);
        send(1'b0, 0, 32'hFFFF_FFC0);
        send(1'b0, 0, 1);
        send(1'b1, 32'h1040, 64);
        send(1'b1, 32'h0800, 32'h0800);
        send(1'b1, 32'h8001, 32'h0FFF);
        send(1'b0, 0, 100);
        send(1'b1, 32'hFFFF_FF00, 32'h0000_0100);
        send(1'b1, 32'hFFFF_FEFF, 32'h1);
        send(1'b1, 32'h7FFF_0000, 32'hFFFF_FFFF);
        send(1'b1, 32'h7FFE_0000, 32'h1_0000);
        send(1'b0, 0, 32'h8000_0000);
        send(1'b0, 0, 32'h7FFF_FFC1);
        drain();
        for (k = 0; k < 20; k++) send(1'b1, 32'h100000 + k * 32'h1000 + 5, 32'h100);
        send(1'b0, 0, 32'h40);
        send(1'b1, 32'h300000, 32'h40);
        hold_off = 1'b1;
        for (k = 0; k < 1160; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: send(1'b0, $urandom(), rand_len());
                4, 5, 6: begin
                    if (live_base.size() != 0) begin
                        a = $urandom_range(0, live_base.size() - 1);
                        send(1'b1, live_base[a], live_len[a]);
                        live_base.delete(a);
                        live_len.delete(a);
                    end else begin
                        send(1'b1, $urandom_range(1, 32'h00FF_FFFF), rand_len());
                    end
                end
                7: send(1'b1, $urandom(), $urandom());
                default: send(1'b1, $urandom_range(1, 32'h0010_0000), rand_len());
            endcase
            if (k == 600) drain();
        end
        drain();
        repeat (50) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.exp_status.size() == 0)
            $display("tb_first_fit_aligned_allocator: done, clean");
        else
            $display("tb_first_fit_aligned_allocator: done, errors");
        $finish;
    end

    initial begin
        #5ms;
        $display("tb_first_fit_aligned_allocator: done, errors");
        $finish;
    end
endmodule
`default_nettype wire
